>>> rtl/tpwa_pkg.sv
// Package: shared types, constants and helpers for the two-level page walk allocator.
`timescale 1ns / 1ps
`default_nettype none

package tpwa_pkg;

    // Table geometry and field widths
    localparam int IDX_W       = 3;                 // index bits per table level
    localparam int ENTRIES     = 1 << IDX_W;        // entries in one table
    localparam int PROC_W      = 4;
    localparam int VPAGE_W     = 2 * IDX_W;
    localparam int FRAME_W     = 8;
    localparam int CNT_W       = 8;
    localparam int NPROC_W     = 5;
    localparam int ALLOC_W     = 9;
    localparam int MAX_PROCS   = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 40;

    // One word of the entry store
    typedef struct packed {
        logic [CNT_W-1:0]   refs;
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]   process_refs;
        logic [CNT_W-1:0]   process_faults;
        logic [CNT_W-1:0]   page_refs;
        logic               out_of_memory;
        logic               page_fault;
        logic               table_fault;
        logic [FRAME_W-1:0] physical_frame;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Increment that sticks at the top value
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/two_level_page_walk_allocator.sv
// Top level: two-level page walk with demand frame allocation over one entry memory.
//
// Usage:
//   s_ channel: one word per memory access (process index, virtual page).
//   m_ channel: one result word per access (frame, fault flags, counters).
//   cfg_ channel: writes the number of processes in use; take it only while idle.
// Timing:
//   An access steps through accept and read first level, read second level,
//   update, hand off; m_tvalid is registered at the hand-off. The two
//   dependent reads on the single entry memory set this sequence.
//   An access that is rejected early (halted or unused process) skips both reads.
//   The next word is accepted the cycle after the result is loaded, so a new
//   access can start while the previous result still waits on m_tready.
// Reset:
//   aresetn clears control state, then the block sweeps the entry memory, one
//   entry a cycle, across all FRAMES*8 entries (2048 at the default) with s_tready low.
// Stalls:
//   A stalled receiver holds the result in the output register; the next access
//   completes its walk and then waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module two_level_page_walk_allocator #(
    parameter int FRAMES = 256
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // Bits [3:0] process_index, [9:4] virtual_page, [15:10] zero
    input  wire  [tpwa_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // Bits [7:0] physical_frame, [8] table_fault, [9] page_fault,
    // [10] out_of_memory, [18:11] page_refs, [26:19] process_faults,
    // [34:27] process_refs, [39:35] zero
    output logic [tpwa_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // Number of processes in use
    input  wire  [tpwa_pkg::NPROC_W-1:0]      cfg_data,
    input  wire                               cfg_valid,
    output logic                              cfg_ready
);

    import tpwa_pkg::*;

    localparam int DEPTH = FRAMES * ENTRIES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [ALLOC_W:0]   FRAMES_LIM = (ALLOC_W + 1)'(FRAMES);
    localparam logic [AW-1:0]      LAST_ADDR  = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK1,
        ST_WALK2,
        ST_DONE
    } state_t;

    // Registers
    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [NPROC_W-1:0]     num_proc_reg, num_proc_next;
    logic [ALLOC_W-1:0]     alloc_count_reg, alloc_count_next;
    logic                   halted_reg, halted_next;
    logic [CNT_W-1:0]       fault_cnt_reg [MAX_PROCS];
    logic [CNT_W-1:0]       fault_cnt_next [MAX_PROCS];
    logic [CNT_W-1:0]       ref_cnt_reg [MAX_PROCS];
    logic [CNT_W-1:0]       ref_cnt_next [MAX_PROCS];
    logic [PROC_W-1:0]      proc_reg, proc_next;
    logic [VPAGE_W-1:0]     vpage_reg, vpage_next;
    logic                   tf_reg, tf_next;
    logic                   fwd_reg, fwd_next;
    entry_t                 fwd_entry_reg, fwd_entry_next;
    logic [AW-1:0]          l2_addr_reg, l2_addr_next;
    result_t                res_reg, res_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // Memory port signals
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    entry_t                 mem_wr_data;
    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic [ENTRY_W-1:0]     mem_rd_data;

    // Shared walk values
    logic [NPROC_W-1:0]     num_eff;
    logic [ALLOC_W:0]       alloc_sum;
    logic                   alloc_ok;
    logic [FRAME_W-1:0]     new_frame;
    logic [AW-1:0]          l1_addr_reg_side;
    logic [PROC_W-1:0]      in_proc;
    logic [VPAGE_W-1:0]     in_vpage;
    entry_t                 e1;
    entry_t                 e2;
    entry_t                 e_upd;
    logic [FRAME_W-1:0]     l2_frame;
    logic [AW-1:0]          l2_addr_c;
    logic [CNT_W-1:0]       faults_now;
    logic [CNT_W-1:0]       refs_now;

    tpwa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Clamp the register and form the next free frame
    assign num_eff   = (num_proc_reg > NPROC_W'(MAX_PROCS)) ? NPROC_W'(MAX_PROCS)
                                                            : num_proc_reg;
    assign alloc_sum = {1'b0, alloc_count_reg} + (ALLOC_W + 1)'(num_eff);
    assign alloc_ok  = (alloc_sum < FRAMES_LIM);
    assign new_frame = alloc_sum[FRAME_W-1:0];

    assign in_proc   = s_tdata[PROC_W-1:0];
    assign in_vpage  = s_tdata[PROC_W +: VPAGE_W];
    assign l1_addr_reg_side = AW'({proc_reg, vpage_reg[VPAGE_W-1:IDX_W]});

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Next-state and memory control
    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        num_proc_next    = num_proc_reg;
        alloc_count_next = alloc_count_reg;
        halted_next      = halted_reg;
        fault_cnt_next   = fault_cnt_reg;
        ref_cnt_next     = ref_cnt_reg;
        proc_next        = proc_reg;
        vpage_next       = vpage_reg;
        tf_next          = tf_reg;
        fwd_next         = fwd_reg;
        fwd_entry_next   = fwd_entry_reg;
        l2_addr_next     = l2_addr_reg;
        res_next         = res_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = clr_addr_reg;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = AW'({in_proc, in_vpage[VPAGE_W-1:IDX_W]});

        e1         = entry_t'(mem_rd_data);
        e2         = fwd_reg ? fwd_entry_reg : entry_t'(mem_rd_data);
        e_upd      = e1;
        l2_frame   = e1.frame;
        l2_addr_c  = '0;
        faults_now = fault_cnt_reg[proc_reg];
        refs_now   = ref_cnt_reg[proc_reg];

        // Take configuration writes at any time
        if (cfg_valid) begin
            num_proc_next = cfg_data;
        end

        // Drop the output word once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_addr_reg;
                mem_wr_data = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    proc_next  = in_proc;
                    vpage_next = in_vpage;
                    tf_next    = 1'b0;
                    fwd_next   = 1'b0;
                    res_next   = '0;
                    priority if (halted_reg) begin
                        res_next.out_of_memory = 1'b1;
                        state_next = ST_DONE;
                    end else if ({1'b0, in_proc} >= num_eff) begin
                        state_next = ST_DONE;
                    end else begin
                        mem_rd_en  = 1'b1;
                        state_next = ST_WALK1;
                    end
                end
            end

            ST_WALK1: begin
                // Allocate a second-level table if the first-level entry is empty; halt when no frame is left
                if (!e1.valid) begin
                    if (!alloc_ok) begin
                        halted_next = 1'b1;
                        res_next = '0;
                        res_next.out_of_memory = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        e_upd.frame = new_frame;
                        e_upd.valid = 1'b1;
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = l1_addr_reg_side;
                        mem_wr_data = e_upd;
                        alloc_count_next = alloc_count_reg + ALLOC_W'(1);
                        tf_next = 1'b1;
                        fault_cnt_next[proc_reg] = sat_inc(fault_cnt_reg[proc_reg]);
                        l2_frame = new_frame;
                    end
                end
                l2_addr_c = AW'({l2_frame, vpage_reg[IDX_W-1:0]});
                if (e1.valid || alloc_ok) begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = l2_addr_c;
                    l2_addr_next = l2_addr_c;
                    // Forward when the page entry is the entry written here
                    fwd_next       = mem_wr_en && (l2_addr_c == l1_addr_reg_side);
                    fwd_entry_next = e_upd;
                    state_next     = ST_WALK2;
                end
            end

            ST_WALK2: begin
                e_upd = e2;
                res_next = '0;
                res_next.table_fault = tf_reg;
                if (!e2.valid && !alloc_ok) begin
                    halted_next = 1'b1;
                    res_next.out_of_memory  = 1'b1;
                    res_next.process_faults = faults_now;
                    res_next.process_refs   = refs_now;
                end else begin
                    if (!e2.valid) begin
                        e_upd.frame = new_frame;
                        e_upd.valid = 1'b1;
                        alloc_count_next = alloc_count_reg + ALLOC_W'(1);
                        faults_now = sat_inc(faults_now);
                        res_next.page_fault = 1'b1;
                    end
                    e_upd.refs = e_upd.refs + CNT_W'(1);
                    refs_now   = sat_inc(refs_now);
                    fault_cnt_next[proc_reg] = faults_now;
                    ref_cnt_next[proc_reg]   = refs_now;
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = l2_addr_reg;
                    mem_wr_data = e_upd;
                    res_next.physical_frame = e_upd.frame;
                    res_next.page_refs      = e_upd.refs;
                    res_next.process_faults = faults_now;
                    res_next.process_refs   = refs_now;
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                // Hand off once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(OUT_DATA_W - RESULT_W)'(0), res_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and registered outputs
    always_ff @(posedge aclk) begin
        proc_reg      <= proc_next;
        vpage_reg     <= vpage_next;
        tf_reg        <= tf_next;
        fwd_entry_reg <= fwd_entry_next;
        l2_addr_reg   <= l2_addr_next;
        res_reg       <= res_next;
        m_tdata_reg   <= m_tdata_next;
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            num_proc_reg    <= NPROC_W'(1);
            alloc_count_reg <= '0;
            halted_reg      <= 1'b0;
            fwd_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < MAX_PROCS; i++) begin
                fault_cnt_reg[i] <= '0;
                ref_cnt_reg[i]   <= '0;
            end
        end else begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            num_proc_reg    <= num_proc_next;
            alloc_count_reg <= alloc_count_next;
            halted_reg      <= halted_next;
            fwd_reg         <= fwd_next;
            m_tvalid_reg    <= m_tvalid_next;
            fault_cnt_reg   <= fault_cnt_next;
            ref_cnt_reg     <= ref_cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tpwa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tpwa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 2048
) (
    input  wire                      aclk,
    input  wire                      wr_en,
    input  wire  [$clog2(DEPTH)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]         wr_data,
    input  wire                      rd_en,
    input  wire  [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read word; a read of the address being written returns the old word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> tb/two_level_page_walk_allocator_tb.sv
// Testbench for the two-level page walk allocator: stream stimulus checked against a walk predictor.
`timescale 1ns / 1ps

module two_level_page_walk_allocator_tb;
    import tpwa_pkg::*;

    // Which kind of miss runs the allocator dry
    typedef enum int {
        OOM_ON_TABLE,
        OOM_ON_PAGE_AFTER_TABLE,
        OOM_ON_PAGE
    } oom_case_t;

    localparam int NUM_FRAMES = 256;
    localparam int POOL_SIZE  = 8;
    localparam int ADDR_SPACE = MAX_PROCS * (1 << VPAGE_W);

    logic                   aclk;
    logic                   aresetn;
    logic [IN_DATA_W-1:0]   s_tdata;    // [3:0] process_index, [9:4] virtual_page
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;    // frame, table/page fault, oom, page/process counts
    logic                   m_tvalid;
    logic                   m_tready;
    logic [NPROC_W-1:0]     cfg_data;
    logic                   cfg_valid;
    logic                   cfg_ready;

    two_level_page_walk_allocator #(
        .FRAMES(NUM_FRAMES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_data (cfg_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready)
    );

    // Walk predictor state
    entry_t             page_store [NUM_FRAMES*ENTRIES];
    logic [ALLOC_W-1:0] frames_handed;
    bit                 walk_halted;
    logic [CNT_W-1:0]   proc_fault_cnt [MAX_PROCS];
    logic [CNT_W-1:0]   proc_ref_cnt [MAX_PROCS];
    logic [NPROC_W-1:0] nproc_reg;
    result_t            pending_results[$];

    int error_count;
    int send_idle_pct;
    int recv_idle_pct;

    // Generate the clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int active_procs();
        return (nproc_reg > MAX_PROCS) ? MAX_PROCS : int'(nproc_reg);
    endfunction

    function automatic int free_frames();
        int left;
        left = NUM_FRAMES - active_procs() - int'(frames_handed);
        return (left < 0) ? 0 : left;
    endfunction

    function automatic logic [CNT_W-1:0] count_up_sat(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // Bump allocator: next free frame sits right above the first-level tables
    function automatic bit take_frame(input int base, output logic [FRAME_W-1:0] fr);
        int next_free;
        next_free = base + int'(frames_handed);
        fr = '0;
        if (next_free >= NUM_FRAMES)
            return 1'b0;
        fr = next_free[FRAME_W-1:0];
        frames_handed = frames_handed + 1'b1;
        return 1'b1;
    endfunction

    // Walk both levels, allocate on misses and return the result word
    function automatic result_t walk_predict(input logic [PROC_W-1:0] p,
                                             input logic [VPAGE_W-1:0] vp);
        result_t            res;
        int                 np;
        int                 l1_at;
        int                 l2_at;
        logic [FRAME_W-1:0] fr;
        bit                 grew_table;
        res = '0;
        np = active_procs();
        grew_table = 1'b0;
        if (walk_halted) begin
            res.out_of_memory = 1'b1;
            return res;
        end
        if (int'(p) >= np)
            return res;
        l1_at = int'(p) * ENTRIES + int'(vp[VPAGE_W-1:IDX_W]);
        if (!page_store[l1_at].valid) begin
            if (!take_frame(np, fr)) begin
                walk_halted = 1'b1;
                res.out_of_memory = 1'b1;
                return res;
            end
            page_store[l1_at].frame = fr;
            page_store[l1_at].valid = 1'b1;
            grew_table = 1'b1;
            proc_fault_cnt[p] = count_up_sat(proc_fault_cnt[p]);
        end
        l2_at = int'(page_store[l1_at].frame) * ENTRIES + int'(vp[IDX_W-1:0]);
        if (!page_store[l2_at].valid) begin
            if (!take_frame(np, fr)) begin
                walk_halted = 1'b1;
                res.table_fault = grew_table;
                res.out_of_memory = 1'b1;
                res.process_faults = proc_fault_cnt[p];
                res.process_refs = proc_ref_cnt[p];
                return res;
            end
            page_store[l2_at].frame = fr;
            page_store[l2_at].valid = 1'b1;
            res.page_fault = 1'b1;
            proc_fault_cnt[p] = count_up_sat(proc_fault_cnt[p]);
        end
        page_store[l2_at].refs = page_store[l2_at].refs + 1'b1;
        proc_ref_cnt[p] = count_up_sat(proc_ref_cnt[p]);
        res.physical_frame = page_store[l2_at].frame;
        res.table_fault = grew_table;
        res.page_refs = page_store[l2_at].refs;
        res.process_faults = proc_fault_cnt[p];
        res.process_refs = proc_ref_cnt[p];
        return res;
    endfunction

    // Find an in-use address whose walk misses at the first level, or hits
    // the first level and misses at the second
    function automatic bit find_target(input bit want_table_miss,
                                       output logic [PROC_W-1:0] p,
                                       output logic [VPAGE_W-1:0] vp);
        int start;
        int idx;
        int l1_at;
        int l2_at;
        bit hit;
        start = $urandom_range(0, ADDR_SPACE - 1);
        p = '0;
        vp = '0;
        for (int k = 0; k < ADDR_SPACE; k++) begin
            idx = (start + k) % ADDR_SPACE;
            if (idx / 64 >= active_procs())
                continue;
            l1_at = (idx / 64) * ENTRIES + (idx % 64) / ENTRIES;
            l2_at = int'(page_store[l1_at].frame) * ENTRIES + idx % ENTRIES;
            if (want_table_miss)
                hit = !page_store[l1_at].valid;
            else
                hit = page_store[l1_at].valid && !page_store[l2_at].valid;
            if (hit) begin
                p = PROC_W'(idx / 64);
                vp = VPAGE_W'(idx % 64);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Drive one access word and record its expected result on acceptance
    task automatic send_access(input logic [PROC_W-1:0] p, input logic [VPAGE_W-1:0] vp);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {{(IN_DATA_W-PROC_W-VPAGE_W){1'b0}}, vp, p};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(walk_predict(p, vp));
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Write the process count once the block has gone idle
    task automatic write_nproc(input logic [NPROC_W-1:0] value);
        stop_sending();
        wait_drained();
        @(negedge aclk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        nproc_reg = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Hits, misses at both levels, unused processes and register extremes
    task automatic test_directed();
        send_idle_pct = 15;
        recv_idle_pct = 50;
        // reset value allows process 0 only
        send_access(0, 0);
        send_access(0, 0);
        send_access(0, 63);
        send_access(0, 7);
        send_access(0, 56);
        send_access(15, 63);
        send_access(1, 0);
        write_nproc(16);
        send_access(15, 63);
        send_access(15, 0);
        send_access(8, 42);
        send_access(0, 0);
        // zero processes: every access is unused
        write_nproc(0);
        send_access(0, 0);
        send_access(15, 21);
        // values above the maximum count as the maximum
        write_nproc(31);
        send_access(15, 63);
        send_access(15, 63);
        write_nproc(17);
        send_access(3, 5);
        write_nproc(1);
    endtask

    // Mostly a small working set of pages, the rest aimed at unused processes
    task automatic test_random_phase(input int n, input int s_pct, input int r_pct);
        logic [PROC_W-1:0]  pool_proc [POOL_SIZE];
        logic [VPAGE_W-1:0] pool_page [POOL_SIZE];
        int                 np;
        int                 pick;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_nproc(NPROC_W'($urandom_range(2, 12)));
        np = active_procs();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_proc[i] = PROC_W'($urandom_range(0, np - 1));
            pool_page[i] = VPAGE_W'($urandom_range(0, 63));
        end
        repeat (n) begin
            if ($urandom_range(0, 99) < 70) begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                send_access(pool_proc[pick], pool_page[pick]);
            end else begin
                send_access(PROC_W'($urandom_range(np, 15)),
                            VPAGE_W'($urandom_range(0, 63)));
            end
        end
    endtask

    // Hammer one page so its count wraps and the process count saturates
    task automatic test_ref_wrap();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_nproc(1);
        repeat (256) send_access(0, 0);
    endtask

    // Use up every frame, end on the chosen kind of miss, then poke the halted block
    task automatic test_out_of_memory();
        oom_case_t          oom_case;
        int                 need;
        int                 tries;
        bit                 found;
        bit                 want_table;
        logic [PROC_W-1:0]  p;
        logic [VPAGE_W-1:0] vp;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_nproc(16);
        oom_case = oom_case_t'($urandom_range(0, 2));
        need = (oom_case == OOM_ON_PAGE_AFTER_TABLE) ? 1 : 0;
        found = 1'b1;
        while (found && !walk_halted && free_frames() > need) begin
            want_table = (free_frames() - need >= 2);
            found = find_target(want_table, p, vp);
            if (!found)
                found = find_target(!want_table, p, vp);
            if (found)
                send_access(p, vp);
        end
        if (find_target(oom_case != OOM_ON_PAGE, p, vp))
            send_access(p, vp);
        // fall back to any miss if the steering fell short
        tries = 0;
        while (!walk_halted && tries < 64) begin
            if (find_target(1'b1, p, vp) || find_target(1'b0, p, vp))
                send_access(p, vp);
            tries++;
        end
        repeat (8) send_access(PROC_W'($urandom_range(0, 15)),
                               VPAGE_W'($urandom_range(0, 63)));
    endtask

    // Drop the receiver ready at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (pending_results.size() == 0) begin
                $display("%0t: result word with no access pending, expected none, actual %h",
                         $time, m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("physical_frame", want.physical_frame, got.physical_frame);
                check_field("table_fault", want.table_fault, got.table_fault);
                check_field("page_fault", want.page_fault, got.page_fault);
                check_field("out_of_memory", want.out_of_memory, got.out_of_memory);
                check_field("page_refs", want.page_refs, got.page_refs);
                check_field("process_faults", want.process_faults, got.process_faults);
                check_field("process_refs", want.process_refs, got.process_refs);
            end
        end
    end

    // Hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        cfg_data = '0;
        cfg_valid = 1'b0;
        error_count = 0;
        send_idle_pct = 15;
        recv_idle_pct = 50;
        foreach (page_store[i])
            page_store[i] = '0;
        foreach (proc_fault_cnt[i]) begin
            proc_fault_cnt[i] = '0;
            proc_ref_cnt[i] = '0;
        end
        frames_handed = '0;
        walk_halted = 1'b0;
        nproc_reg = 1;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_phase(25, 15, 50);
        test_random_phase(25, 50, 15);
        test_random_phase(25, 0, 0);
        test_ref_wrap();
        test_out_of_memory();

        stop_sending();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
